[rtl/core/hsg_pkg.sv]
// Shared types, constants and sine table arithmetic for the harmonic sum generator.
package hsg_pkg;

  localparam int unsigned HC_W        = 5;
  localparam int unsigned FS_W        = 10;
  localparam int unsigned CFG_W       = 10;
  localparam int unsigned HIDX_W      = 4;
  localparam int unsigned AMP_W       = 2;
  localparam int unsigned PH_W        = 4;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned SAMPLE_W    = 19;
  localparam int unsigned FT_W        = FS_W + TIME_W;
  localparam int unsigned ARG_W       = 32;
  localparam int unsigned SIN_W       = 14;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // 1/(2pi) as unsigned Q0.64, split in halves
  localparam logic [31:0] INV2PI_HI = 32'h28BE60DB;
  localparam logic [31:0] INV2PI_LO = 32'h9391054A;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] TURN_Q30   = 64'd1073741824;
  localparam logic [63:0] HTURN_Q30  = 64'd536870912;
  localparam logic [63:0] QTURN_Q30  = 64'd268435456;
  localparam logic [63:0] TQTURN_Q30 = 64'd805306368;
  localparam logic [63:0] SIN_CAP    = 64'd4096;
  localparam logic [63:0] ROUND_HALF = 64'd131072;

  localparam logic [63:0] TAYLOR_DIV [4] = '{64'd6, 64'd20, 64'd42, 64'd72};

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 19'sd262143;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -19'sd262144;

  typedef enum logic {
    CFG_HARMONIC_COUNT = 1'b0,
    CFG_FREQ_STEP      = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } back_state_e;

  typedef struct packed {
    op_e              op;
    logic [HIDX_W-1:0] index;
    logic [AMP_W-1:0]  amp;
    logic [PH_W-1:0]   phase;
    logic [FT_W-1:0]   ft;
    logic [HC_W-1:0]   cnt;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // Q1.12 sine of a Q30 turn fraction q (below one turn), by quarter fold and Taylor series
  function automatic logic signed [SIN_W-1:0] sine_from_q(logic [63:0] q);
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic        neg;
    neg = 1'b0;
    if (q < QTURN_Q30) begin
      m = q;
    end else if (q <= HTURN_Q30) begin
      m = HTURN_Q30 - q;
    end else if (q < TQTURN_Q30) begin
      m   = q - HTURN_Q30;
      neg = 1'b1;
    end else begin
      m   = TURN_Q30 - q;
      neg = 1'b1;
    end
    x    = (m * TWO_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int j = 0; j < 4; j++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[j];
      if ((j & 1) == 0) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + ROUND_HALF) >> 18;
    if (v > SIN_CAP) begin
      v = SIN_CAP;
    end
    return neg ? -SIN_W'(v) : SIN_W'(v);
  endfunction

endpackage

[rtl/core/harmonic_sum_generator.sv]
// Top level of the harmonic sum generator: front end, job queue and back end.
//
//  channel | direction | handshake                  | words
//  cfg     | in        | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//  in      | in        | in_valid_i / in_stall_o    | op, harmonic_index, amplitude, phase, time_req
//  out     | out       | out_valid_o / out_stall_i  | sample
//
// Load word: written to the harmonic table as it is popped. Sample word: in the back end,
// one harmonic issued per cycle into a five-stage pipeline (table read, phase add,
// two 32x32 multiplies, sine ROM read) feeding the accumulator, then saturation into
// the output register once the pipeline has drained.
// Reset clears control state only; harmonic table entries are undefined until loaded.
// A two-word queue keeps the input open while the back end works; a waiting output
// word holds the back end in its final state until taken.
module harmonic_sum_generator #(
  parameter int unsigned MAX_HARMONICS    = 16,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [hsg_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic [hsg_pkg::HIDX_W-1:0]          harmonic_index_i,
  input  logic [hsg_pkg::AMP_W-1:0]           amplitude_i,
  input  logic [hsg_pkg::PH_W-1:0]            phase_i,
  input  logic [hsg_pkg::TIME_W-1:0]          time_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [hsg_pkg::SAMPLE_W-1:0] sample_o
);

  hsg_pkg::queue_status_t q_status;
  hsg_pkg::job_t          push_job;
  hsg_pkg::job_t          head_job;
  logic                   push;
  logic                   pop;

  hsg_front #(
    .MAX_HARMONICS(MAX_HARMONICS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .harmonic_index_i(harmonic_index_i),
    .amplitude_i     (amplitude_i),
    .phase_i         (phase_i),
    .time_req_i      (time_req_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .job_o           (push_job)
  );

  hsg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .status_o(q_status)
  );

  hsg_back #(
    .MAX_HARMONICS   (MAX_HARMONICS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sample_o   (sample_o)
  );

endmodule

[rtl/core/hsg_front.sv]
// Front end: configuration registers, input word acceptance and job classification.
module hsg_front #(
  parameter int unsigned MAX_HARMONICS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [hsg_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [hsg_pkg::HIDX_W-1:0]    harmonic_index_i,
  input  logic [hsg_pkg::AMP_W-1:0]     amplitude_i,
  input  logic [hsg_pkg::PH_W-1:0]      phase_i,
  input  logic [hsg_pkg::TIME_W-1:0]    time_req_i,
  input  hsg_pkg::queue_status_t        q_status_i,
  output logic                          push_o,
  output hsg_pkg::job_t                 job_o
);

  logic [hsg_pkg::HC_W-1:0] hc_q;
  logic [hsg_pkg::FS_W-1:0] fs_q;
  logic                     accept;
  logic                     idx_ok;
  logic                     is_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= hsg_pkg::HC_W'(1);
      fs_q <= hsg_pkg::FS_W'(1);
    end else if (cfg_we_i) begin
      case (hsg_pkg::cfg_idx_e'(cfg_idx_i))
        hsg_pkg::CFG_HARMONIC_COUNT: hc_q <= cfg_wdata_i[hsg_pkg::HC_W-1:0];
        hsg_pkg::CFG_FREQ_STEP:      fs_q <= cfg_wdata_i[hsg_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign is_sample  = (hsg_pkg::op_e'(op_i) == hsg_pkg::OP_SAMPLE);
  assign idx_ok     = (32'(harmonic_index_i) < MAX_HARMONICS);

  // out-of-range loads are taken and dropped
  assign push_o = accept && (is_sample || idx_ok);

  always_comb begin
    job_o       = '0;
    job_o.op    = hsg_pkg::op_e'(op_i);
    job_o.index = harmonic_index_i;
    job_o.amp   = amplitude_i;
    job_o.phase = phase_i;
    job_o.ft    = hsg_pkg::FT_W'(fs_q) * hsg_pkg::FT_W'(time_req_i);
    job_o.cnt   = (32'(hc_q) > MAX_HARMONICS) ? hsg_pkg::HC_W'(MAX_HARMONICS) : hc_q;
  end

endmodule

[rtl/core/hsg_queue.sv]
// Short job queue between front and back end.
module hsg_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  hsg_pkg::job_t          data_i,
  input  logic                   pop_i,
  output hsg_pkg::job_t          data_o,
  output hsg_pkg::queue_status_t status_o
);

  hsg_pkg::job_t                  mem_q [hsg_pkg::QUEUE_DEPTH];
  logic [hsg_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [hsg_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [hsg_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                           do_push;
  logic                           do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == hsg_pkg::QCNT_W'(hsg_pkg::QUEUE_DEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign data_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == hsg_pkg::QPTR_W'(hsg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == hsg_pkg::QPTR_W'(hsg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/core/hsg_sine_rom.sv]
// Sine lookup ROM, Q1.12 entries over one turn, registered read.
module hsg_sine_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr_i,
  output logic signed [hsg_pkg::SIN_W-1:0]    data_o
);

  typedef logic signed [hsg_pkg::SIN_W-1:0] rom_t [SINE_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned k = 0; k < SINE_TABLE_DEPTH; k++) begin
      r[k] = hsg_pkg::sine_from_q((64'(k) << 30) / 64'(SINE_TABLE_DEPTH));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic signed [hsg_pkg::SIN_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SINE_ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

[rtl/core/hsg_back.sv]
// Back end: harmonic table, issue sequencer, phase/sine pipeline, accumulator, output register.
module hsg_back #(
  parameter int unsigned MAX_HARMONICS    = 16,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hsg_pkg::queue_status_t               q_status_i,
  input  hsg_pkg::job_t                        job_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [hsg_pkg::SAMPLE_W-1:0]  sample_o
);

  localparam int unsigned TAW    = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int unsigned ENT_W  = hsg_pkg::AMP_W + hsg_pkg::PH_W;
  localparam int unsigned ACC_W  = 20 + $clog2(MAX_HARMONICS + 1);
  localparam int unsigned RAW    = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned IDXP_W = 32 + $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned MUL_W  = hsg_pkg::SIN_W + 3;

  hsg_pkg::back_state_e state_q, state_d;

  logic tab_we, start, issue, emit, out_free, pipe_busy;

  logic [ENT_W-1:0]               tab_mem [MAX_HARMONICS];
  logic [ENT_W-1:0]               tab_rd_q;

  logic [hsg_pkg::HC_W-1:0]       cnt_q;
  logic [hsg_pkg::HC_W-1:0]       iss_q;
  logic [hsg_pkg::FT_W-1:0]       ft_q;
  logic [hsg_pkg::ARG_W-1:0]      racc_q;
  logic [hsg_pkg::ARG_W-1:0]      racc_nxt;

  logic                           s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic [hsg_pkg::ARG_W-1:0]      s1_rad_q;
  logic [hsg_pkg::ARG_W-1:0]      s2_arg_q, s3_arg_q;
  logic [hsg_pkg::AMP_W-1:0]      s2_amp_q, s3_amp_q, s4_amp_q, s5_amp_q;
  logic [31:0]                    s3_plo_q;
  logic [31:0]                    s4_frac_q;
  logic [63:0]                    prod_lo;
  logic [31:0]                    prod_hi;
  logic [IDXP_W-1:0]              idx_prod;
  logic [RAW-1:0]                 rom_addr;
  logic signed [hsg_pkg::SIN_W-1:0] sin_val;
  logic signed [MUL_W-1:0]        term;
  logic signed [ACC_W-1:0]        acc_q;

  logic                                  out_valid_q;
  logic signed [hsg_pkg::SAMPLE_W-1:0]   sample_q;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pipe_busy = s1_v_q || s2_v_q || s3_v_q || s4_v_q || s5_v_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hsg_pkg::BK_IDLE: begin
        if (!q_status_i.empty && job_i.op == hsg_pkg::OP_SAMPLE) begin
          state_d = (job_i.cnt == '0) ? hsg_pkg::BK_DRAIN : hsg_pkg::BK_RUN;
        end
      end
      hsg_pkg::BK_RUN: begin
        if (iss_q == cnt_q - 1'b1) begin
          state_d = hsg_pkg::BK_DRAIN;
        end
      end
      hsg_pkg::BK_DRAIN: begin
        if (!pipe_busy && out_free) begin
          state_d = hsg_pkg::BK_IDLE;
        end
      end
      default: state_d = hsg_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o  = 1'b0;
    tab_we = 1'b0;
    start  = 1'b0;
    issue  = 1'b0;
    emit   = 1'b0;
    case (state_q)
      hsg_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          if (job_i.op == hsg_pkg::OP_LOAD) begin
            tab_we = 1'b1;
          end else begin
            start = 1'b1;
          end
        end
      end
      hsg_pkg::BK_RUN:   issue = 1'b1;
      hsg_pkg::BK_DRAIN: emit  = !pipe_busy && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsg_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // harmonic table
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[TAW'(job_i.index)] <= {job_i.amp, job_i.phase};
    end
  end

  always_ff @(posedge clk_i) begin
    tab_rd_q <= tab_mem[TAW'(iss_q)];
  end

  // issue sequencer; racc walks through (i+1) * freq_step * t
  assign racc_nxt = racc_q + hsg_pkg::ARG_W'(ft_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= '0;
    end else if (start) begin
      iss_q <= '0;
    end else if (issue) begin
      iss_q <= iss_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cnt_q  <= job_i.cnt;
      ft_q   <= job_i.ft;
      racc_q <= '0;
    end else if (issue) begin
      racc_q <= racc_nxt;
    end
    s1_rad_q <= racc_nxt;
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  // radians to turns: frac = arg * (1/2pi) mod 1, top 32 bits
  assign prod_lo  = 64'(s2_arg_q) * 64'(hsg_pkg::INV2PI_LO);
  assign prod_hi  = 32'(s3_arg_q * hsg_pkg::INV2PI_HI);
  assign idx_prod = IDXP_W'(s4_frac_q) * IDXP_W'(SINE_TABLE_DEPTH);
  assign rom_addr = idx_prod[32 +: RAW];

  always_ff @(posedge clk_i) begin
    s2_arg_q  <= s1_rad_q + hsg_pkg::ARG_W'(tab_rd_q[hsg_pkg::PH_W-1:0]);
    s2_amp_q  <= tab_rd_q[ENT_W-1:hsg_pkg::PH_W];
    s3_plo_q  <= prod_lo[63:32];
    s3_arg_q  <= s2_arg_q;
    s3_amp_q  <= s2_amp_q;
    s4_frac_q <= prod_hi + s3_plo_q;
    s4_amp_q  <= s3_amp_q;
    s5_amp_q  <= s4_amp_q;
  end

  hsg_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(sin_val)
  );

  assign term = MUL_W'($signed({1'b0, s5_amp_q})) * MUL_W'(sin_val);

  always_ff @(posedge clk_i) begin
    if (start) begin
      acc_q <= '0;
    end else if (s5_v_q) begin
      acc_q <= acc_q + ACC_W'(term);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (acc_q > ACC_W'(hsg_pkg::SAMPLE_MAX)) begin
        sample_q <= hsg_pkg::SAMPLE_MAX;
      end else if (acc_q < ACC_W'(hsg_pkg::SAMPLE_MIN)) begin
        sample_q <= hsg_pkg::SAMPLE_MIN;
      end else begin
        sample_q <= hsg_pkg::SAMPLE_W'(acc_q);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

[rtl/core/hsg_checker.sv]
// Port-level checks for the harmonic sum generator, bound to the top level.
module hsg_checker #(
  parameter int unsigned MAX_HARMONICS = 16
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [hsg_pkg::SAMPLE_W-1:0] sample_o
);

  localparam int HCOUNT    = (MAX_HARMONICS < 31) ? MAX_HARMONICS : 31;
  localparam int SUM_BOUND = 3 * 4096 * HCOUNT;
  localparam int LIM       = (SUM_BOUND > 262143) ? 262143 : SUM_BOUND;

  // queue can only fill on the edge after a word went in
  a_stall_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without a preceding accepted word");

  // sum of at most HCOUNT terms of amplitude three and unit sine
  a_sample_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(sample_o) <= LIM) && (32'(sample_o) >= -LIM))
    else $error("sample outside reachable range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sample_o))
    else $error("stalled sample changed");

endmodule

bind harmonic_sum_generator hsg_checker #(
  .MAX_HARMONICS(MAX_HARMONICS)
) u_hsg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .sample_o   (sample_o)
);
